// ===== rtl/vrll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel run-length loader package
// Shared types, codes and constants for the loader, its controller and its
// datapath.
// ----------------------------------------------------------------------------
package vrll_pkg;

  // Default side length of the cubic grid.
  localparam int GRID_SIDE_DEF = 16;
  // Width of a position counter; it must hold a position plus a skip nibble.
  localparam int POS_W  = 5;
  localparam int CELL_W = 19;

  // Request action codes.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  // Spare action code; it changes nothing and reads no cell.
  localparam logic [1:0] ACT_NOP   = 2'd3;

  localparam logic [7:0] END_MARK = 8'hFF;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] stream_byte;
    logic [3:0] read_x;
    logic [3:0] read_y;
    logic [3:0] read_z;
  } in_t;

  typedef struct packed {
    logic [1:0] load_state;
    logic [7:0] cell_occupancy;
    logic [9:0] cell_material;
    logic       cell_full;
  } out_t;

  typedef enum logic [1:0] {
    LS_IDLE    = 2'd0,
    LS_LOADING = 2'd1,
    LS_LOADED  = 2'd2,
    LS_ERROR   = 2'd3
  } lstate_t;

  typedef enum logic [2:0] {
    PH_ROW  = 3'd0,
    PH_CELL = 3'd1,
    PH_PROP = 3'd2,
    PH_EXT  = 3'd3,
    PH_OCC  = 3'd4
  } phase_t;

  // Decoder position and progress.
  typedef struct packed {
    logic [POS_W-1:0] layer;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] slot;
    phase_t           phase;
    logic [3:0]       prow;
    logic [3:0]       pcell;
    lstate_t          status;
  } pos_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_CAPTURE,
    CMD_EXEC,
    CMD_FILL,
    CMD_COPY_RD,
    CMD_COPY_WR,
    CMD_ROW_END,
    CMD_READ_CAP,
    CMD_OUT
  } cmd_t;

  typedef enum logic [1:0] {
    EX_DONE,
    EX_FILL,
    EX_COPY,
    EX_READ
  } exec_kind_t;

  typedef struct packed {
    exec_kind_t exec_kind;
    logic       fill_last;
    logic       fill_copy;
    logic       copy_wr_last;
    logic       copy_z_last;
    logic       clear_last;
  } dp_status_t;

  typedef enum logic [3:0] {
    C_CLEAR,
    C_IDLE,
    C_EXEC,
    C_FILL,
    C_COPY_RD,
    C_COPY_WR,
    C_ROW_END,
    C_READ,
    C_DONE
  } ctrl_state_t;

endpackage

// ===== rtl/vrll_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module vrll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/vrll_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel loader controller
// Sequences the clearing pass, byte decode, cell fills, row copies, reads and
// the output register hand-off.
// ----------------------------------------------------------------------------
module vrll_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  vrll_pkg::dp_status_t st,
  output vrll_pkg::cmd_t       cmd
);

  vrll_pkg::ctrl_state_t state, state_next;
  logic                  out_load;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vrll_pkg::C_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = vrll_pkg::CMD_NONE;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      vrll_pkg::C_CLEAR: begin
        cmd = vrll_pkg::CMD_CLEAR;
        if (st.clear_last) begin
          state_next = vrll_pkg::C_IDLE;
        end
      end
      vrll_pkg::C_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = vrll_pkg::CMD_CAPTURE;
          state_next = vrll_pkg::C_EXEC;
        end
      end
      vrll_pkg::C_EXEC: begin
        cmd = vrll_pkg::CMD_EXEC;
        unique case (st.exec_kind)
          vrll_pkg::EX_FILL: state_next = vrll_pkg::C_FILL;
          vrll_pkg::EX_COPY: state_next = vrll_pkg::C_COPY_RD;
          vrll_pkg::EX_READ: state_next = vrll_pkg::C_READ;
          default:           state_next = vrll_pkg::C_DONE;
        endcase
      end
      vrll_pkg::C_FILL: begin
        cmd = vrll_pkg::CMD_FILL;
        if (st.fill_last) begin
          state_next = st.fill_copy ? vrll_pkg::C_COPY_RD : vrll_pkg::C_DONE;
        end
      end
      vrll_pkg::C_COPY_RD: begin
        cmd        = vrll_pkg::CMD_COPY_RD;
        state_next = vrll_pkg::C_COPY_WR;
      end
      vrll_pkg::C_COPY_WR: begin
        cmd = vrll_pkg::CMD_COPY_WR;
        if (st.copy_wr_last) begin
          state_next = st.copy_z_last ? vrll_pkg::C_ROW_END : vrll_pkg::C_COPY_RD;
        end
      end
      vrll_pkg::C_ROW_END: begin
        cmd        = vrll_pkg::CMD_ROW_END;
        state_next = vrll_pkg::C_DONE;
      end
      vrll_pkg::C_READ: begin
        cmd        = vrll_pkg::CMD_READ_CAP;
        state_next = vrll_pkg::C_DONE;
      end
      vrll_pkg::C_DONE: begin
        if (!out_valid || out_ready) begin
          cmd        = vrll_pkg::CMD_OUT;
          out_load   = 1'b1;
          state_next = vrll_pkg::C_IDLE;
        end
      end
      default: state_next = vrll_pkg::C_CLEAR;
    endcase
  end

endmodule

// ===== rtl/vrll_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel loader datapath
// Holds the decoder position, the pending cell and the voxel store, and
// carries out the commands of the controller.
// ----------------------------------------------------------------------------
module vrll_dp #(
  parameter int GRID_SIDE = vrll_pkg::GRID_SIDE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  vrll_pkg::cmd_t       cmd,
  input  vrll_pkg::in_t        in_req,
  output vrll_pkg::out_t       out_rsp,
  output vrll_pkg::dp_status_t st
);

  localparam int CW    = $clog2(GRID_SIDE);
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam logic [5:0] GS6 = 6'(GRID_SIDE);
  localparam logic [CW-1:0] Z_LAST = CW'(GRID_SIDE - 1);

  vrll_pkg::in_t  req;
  vrll_pkg::pos_t pos, pos_end_layer, pos_row_end, pos_start;
  logic           pfull;
  logic [9:0]     pmat;
  logic [7:0]     occ;
  logic [3:0]     fill_i;
  logic [3:0]     copy_i;
  logic [CW-1:0]  copy_z;
  logic [AW-1:0]  clr_cnt;
  logic [vrll_pkg::CELL_W-1:0] cell_reg;

  logic [7:0] b;
  logic [3:0] skip, rep;
  logic [5:0] row_sk, row_chk, cell_sk, cell_chk, row_new, layer_new, cell_after;
  logic [4:0] fill_z, copy_y;
  logic       loading, in_grid, row_full;
  logic [9:0] ext_mat;

  logic                        we, re;
  logic [AW-1:0]               waddr, raddr;
  logic [vrll_pkg::CELL_W-1:0] wdata, rdata;

  // Byte fields and position arithmetic.
  assign b          = req.stream_byte;
  assign skip       = b[7:4];
  assign rep        = b[3:0];
  assign row_sk     = {1'b0, pos.row} + 6'(skip);
  assign row_chk    = row_sk + 6'(rep);
  assign cell_sk    = {1'b0, pos.slot} + 6'(skip);
  assign cell_chk   = cell_sk + 6'(rep);
  assign row_new    = {1'b0, pos.row} + 6'(pos.prow) + 6'd1;
  assign layer_new  = {1'b0, pos.layer} + 6'd1;
  assign cell_after = {1'b0, pos.slot} + 6'(pos.pcell) + 6'd1;
  assign row_full   = cell_after >= GS6;
  assign fill_z     = pos.slot + 5'(fill_i);
  assign copy_y     = pos.row + 5'(copy_i);
  assign ext_mat    = 10'({pmat, 5'b0} | {7'b0, b});
  assign loading    = pos.status == vrll_pkg::LS_LOADING;
  assign in_grid    = ({1'b0, req.read_x} < 5'(GRID_SIDE)) &&
                      ({1'b0, req.read_y} < 5'(GRID_SIDE)) &&
                      ({1'b0, req.read_z} < 5'(GRID_SIDE));

  // Position at the start of a load.
  always_comb begin
    pos_start        = '0;
    pos_start.status = vrll_pkg::LS_LOADING;
  end

  // Position after a layer ends.
  always_comb begin
    pos_end_layer       = pos;
    pos_end_layer.layer = layer_new[vrll_pkg::POS_W-1:0];
    pos_end_layer.row   = '0;
    pos_end_layer.slot  = '0;
    pos_end_layer.phase = vrll_pkg::PH_ROW;
    pos_end_layer.pcell = '0;
    pos_end_layer.prow  = '0;
    if (layer_new >= GS6) begin
      pos_end_layer.status = vrll_pkg::LS_LOADED;
    end
  end

  // Position after a row and its copies are complete.
  always_comb begin
    if (row_new >= GS6) begin
      pos_row_end = pos_end_layer;
    end else begin
      pos_row_end       = pos;
      pos_row_end.row   = row_new[vrll_pkg::POS_W-1:0];
      pos_row_end.phase = vrll_pkg::PH_ROW;
      pos_row_end.prow  = '0;
      pos_row_end.pcell = '0;
    end
  end

  // Status towards the controller.
  always_comb begin
    st.exec_kind = vrll_pkg::EX_DONE;
    if (req.action == vrll_pkg::ACT_BYTE && loading) begin
      unique case (pos.phase)
        vrll_pkg::PH_CELL:
          if (b == vrll_pkg::END_MARK && pos.prow != 4'd0) st.exec_kind = vrll_pkg::EX_COPY;
        vrll_pkg::PH_PROP:
          if (!b[5] && b[7]) st.exec_kind = vrll_pkg::EX_FILL;
        vrll_pkg::PH_EXT:
          if (pfull) st.exec_kind = vrll_pkg::EX_FILL;
        vrll_pkg::PH_OCC:
          st.exec_kind = vrll_pkg::EX_FILL;
        default: st.exec_kind = vrll_pkg::EX_DONE;
      endcase
    end else if (req.action == vrll_pkg::ACT_READ && in_grid) begin
      st.exec_kind = vrll_pkg::EX_READ;
    end
    st.fill_last    = fill_i == pos.pcell;
    st.fill_copy    = st.fill_last && row_full && pos.prow != 4'd0;
    st.copy_wr_last = copy_i == pos.prow;
    st.copy_z_last  = copy_z == Z_LAST;
    st.clear_last   = &clr_cnt;
  end

  // Store port selection.
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = '0;
    unique case (cmd)
      vrll_pkg::CMD_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
      end
      vrll_pkg::CMD_EXEC: begin
        re    = st.exec_kind == vrll_pkg::EX_READ;
        raddr = {req.read_x[CW-1:0], req.read_y[CW-1:0], req.read_z[CW-1:0]};
      end
      vrll_pkg::CMD_FILL: begin
        we    = 1'b1;
        waddr = {pos.layer[CW-1:0], pos.row[CW-1:0], fill_z[CW-1:0]};
        wdata = {pfull, pmat, occ};
      end
      vrll_pkg::CMD_COPY_RD: begin
        re    = 1'b1;
        raddr = {pos.layer[CW-1:0], pos.row[CW-1:0], copy_z};
      end
      vrll_pkg::CMD_COPY_WR: begin
        we    = 1'b1;
        waddr = {pos.layer[CW-1:0], copy_y[CW-1:0], copy_z};
        wdata = rdata;
      end
      default: we = 1'b0;
    endcase
  end

  // Decoder registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      pfull      <= 1'b0;
      pmat       <= '0;
      occ        <= '0;
      fill_i     <= '0;
      copy_i     <= 4'd1;
      copy_z     <= '0;
      clr_cnt    <= '0;
    end else begin
      unique case (cmd)
        vrll_pkg::CMD_CLEAR: clr_cnt <= clr_cnt + AW'(1);
        vrll_pkg::CMD_CAPTURE: req <= in_req;
        vrll_pkg::CMD_EXEC: begin
          cell_reg <= '0;
          fill_i   <= '0;
          copy_i   <= 4'd1;
          copy_z   <= '0;
          if (req.action == vrll_pkg::ACT_START) begin
            pos        <= pos_start;
            pfull      <= 1'b0;
            pmat       <= '0;
          end else if (req.action == vrll_pkg::ACT_BYTE && loading) begin
            unique case (pos.phase)
              vrll_pkg::PH_ROW: begin
                if (b == vrll_pkg::END_MARK) begin
                  pos <= pos_end_layer;
                end else begin
                  pos.row <= row_sk[vrll_pkg::POS_W-1:0];
                  if (row_chk >= GS6) begin
                    pos.status <= vrll_pkg::LS_ERROR;
                  end else begin
                    pos.prow  <= rep;
                    pos.slot  <= '0;
                    pos.phase <= vrll_pkg::PH_CELL;
                  end
                end
              end
              vrll_pkg::PH_CELL: begin
                if (b == vrll_pkg::END_MARK) begin
                  // A row without copies ends at once; otherwise the copy runs first.
                  if (pos.prow == 4'd0) pos <= pos_row_end;
                end else begin
                  pos.slot <= cell_sk[vrll_pkg::POS_W-1:0];
                  if (cell_chk >= GS6) begin
                    pos.status <= vrll_pkg::LS_ERROR;
                  end else begin
                    pos.pcell <= rep;
                    pos.phase <= vrll_pkg::PH_PROP;
                  end
                end
              end
              vrll_pkg::PH_PROP: begin
                pfull <= b[7];
                pmat  <= {5'b0, b[4:0]};
                occ   <= '0;
                if (b[5]) begin
                  pos.phase <= vrll_pkg::PH_EXT;
                end else if (!b[7]) begin
                  pos.phase <= vrll_pkg::PH_OCC;
                end
              end
              vrll_pkg::PH_EXT: begin
                pmat <= ext_mat;
                occ  <= '0;
                if (!pfull) pos.phase <= vrll_pkg::PH_OCC;
              end
              vrll_pkg::PH_OCC: occ <= b;
              default: pos.status <= vrll_pkg::LS_ERROR;
            endcase
          end
        end
        vrll_pkg::CMD_FILL: begin
          fill_i <= fill_i + 4'd1;
          if (st.fill_last) begin
            if (!row_full) begin
              pos.slot  <= cell_after[vrll_pkg::POS_W-1:0];
              pos.pcell <= '0;
              pos.phase <= vrll_pkg::PH_CELL;
            end else if (pos.prow == 4'd0) begin
              pos <= pos_row_end;
            end else begin
              pos.slot  <= cell_after[vrll_pkg::POS_W-1:0];
              pos.pcell <= '0;
            end
          end
        end
        vrll_pkg::CMD_COPY_WR: begin
          if (st.copy_wr_last) begin
            copy_i <= 4'd1;
            copy_z <= copy_z + CW'(1);
          end else begin
            copy_i <= copy_i + 4'd1;
          end
        end
        vrll_pkg::CMD_ROW_END: pos <= pos_row_end;
        vrll_pkg::CMD_READ_CAP: cell_reg <= rdata;
        vrll_pkg::CMD_OUT: begin
          out_rsp.load_state     <= pos.status;
          out_rsp.cell_occupancy <= cell_reg[7:0];
          out_rsp.cell_material  <= cell_reg[17:8];
          out_rsp.cell_full      <= cell_reg[18];
        end
        default: clr_cnt <= clr_cnt;
      endcase
    end
  end

  vrll_ram #(
    .WIDTH(vrll_pkg::CELL_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule

// ===== rtl/voxel_run_length_loader_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel run-length loader
// Decodes a run-length byte stream into a cubic voxel store and reads cells.
// ----------------------------------------------------------------------------
// The response is registered after its request passes the capture, execute and done
// states; a read also captures the stored cell. A cell with repeat r writes its r+1
// cells in the fill state; a row copy with repeat r copies each cell of the row to the
// r following rows, then ends the row. The next request is taken only once the response
// is registered, even while that response waits. Reset: the clearing pass writes all
// 2**(3*clog2(GRID_SIDE)) store cells (4096 at 16), and no request is taken until then.
module voxel_run_length_loader_unit #(
  parameter int GRID_SIDE = vrll_pkg::GRID_SIDE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  vrll_pkg::in_t  in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output vrll_pkg::out_t out_rsp
);

  vrll_pkg::cmd_t       cmd;
  vrll_pkg::dp_status_t st;

  vrll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .st       (st),
    .cmd      (cmd)
  );

  vrll_dp #(
    .GRID_SIDE(GRID_SIDE)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .in_req (in_req),
    .out_rsp(out_rsp),
    .st     (st)
  );

endmodule

// ===== rtl/vrll_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel loader checker
// Port-level checks on the loader, attached to the top level.
// ----------------------------------------------------------------------------
module vrll_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input vrll_pkg::out_t out_rsp
);

  // A waiting response holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("response changed while stalled");

  // A full cell never carries an occupancy byte.
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.cell_full |-> out_rsp.cell_occupancy == 8'd0)
    else $error("full cell with occupancy");

  // The clearing pass blocks requests after reset.
  a_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("request taken during clearing pass");

  // One request is in work at a time.
  a_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

endmodule

bind voxel_run_length_loader_unit vrll_checker u_vrll_checker (.*);
